// File: rtl/fhc_pkg.sv
// ----------------------------------------------------------------------------
// fhc_pkg: shared types and constants of the frame header classifier
// Holds the frame kind codes, the protocol constants and the result type.
// ----------------------------------------------------------------------------
package fhc_pkg;

	localparam int unsigned MaxFrameBytes = 16383;
	localparam int unsigned CountW = 14;

	localparam logic [15:0] EtIpv4 = 16'h0800;
	localparam logic [15:0] EtIpv6 = 16'h86DD;
	localparam logic [15:0] EtArp  = 16'h0806;
	localparam logic [15:0] EtVlan = 16'h8100;
	localparam logic [15:0] EtQinq = 16'h88A8;
	localparam logic [4:0]  L3Base = 5'd14;
	localparam logic [4:0]  L3LastTag = 5'd22;

	localparam logic [7:0] ProtoTcp = 8'd6;
	localparam logic [7:0] ProtoUdp = 8'd17;

	localparam logic [1:0] IpNone = 2'd0;
	localparam logic [1:0] IpV4   = 2'd1;
	localparam logic [1:0] IpV6   = 2'd2;

	localparam logic [3:0] KindIgnored   = 4'd0;
	localparam logic [3:0] KindRaw       = 4'd1;
	localparam logic [3:0] KindArp       = 4'd2;
	localparam logic [3:0] KindDns       = 4'd3;
	localparam logic [3:0] KindTlsClient = 4'd4;
	localparam logic [3:0] KindTlsServer = 4'd5;
	localparam logic [3:0] KindSsdp      = 4'd6;
	localparam logic [3:0] KindDhcp      = 4'd7;
	localparam logic [3:0] KindAggregate = 4'd8;

	typedef struct packed {
		logic [3:0]        frame_kind;
		logic [11:0]       vlan_id;
		logic [15:0]       ether_type;
		logic [1:0]        ip_version;
		logic [7:0]        l4_protocol;
		logic [7:0]        ip_ttl;
		logic [15:0]       src_port;
		logic [15:0]       dst_port;
		logic [7:0]        tcp_flag_bits;
		logic [CountW-1:0] payload_offset;
		logic [CountW-1:0] frame_length;
	} result_t;

	typedef struct packed {
		logic [CountW-1:0] byte_count;
		logic [15:0]       ethertype;
		logic [11:0]       vlan;
		logic [4:0]        l3_start;
		logic [1:0]        ip_kind;
		logic [5:0]        ip_hlen;
		logic [7:0]        proto;
		logic [7:0]        ttl;
		logic [15:0]       sport;
		logic [15:0]       dport;
		logic [7:0]        flags;
		logic [5:0]        tcp_hlen;
		logic [7:0]        first_payload;
		logic [7:0]        hs_type;
		logic              later_frag;
	} parse_t;

endpackage

// File: rtl/fhc_parser.sv
// ----------------------------------------------------------------------------
// fhc_parser: header field capture
// Holds the per-frame parse state and updates it with each accepted byte.
// ----------------------------------------------------------------------------
module fhc_parser (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            take,
	input  logic [7:0]      data_byte,
	input  logic            end_of_frame,
	output fhc_pkg::parse_t nxt
);
	import fhc_pkg::*;

	parse_t st_q;
	parse_t n;
	parse_t clr;
	logic [CountW-1:0] p;
	logic [CountW-1:0] l3;
	logic [CountW-1:0] rel;
	logic [CountW-1:0] r4;
	logic [7:0] pr;
	logic [CountW-1:0] po;
	logic po_ok;
	logic [15:0] et;

	always_comb begin
		clr = '0;
		clr.l3_start = L3Base;
	end

	always_comb begin
		n = st_q;
		p = st_q.byte_count;
		l3 = CountW'(st_q.l3_start);
		rel = '0;
		r4 = '0;
		pr = '0;
		po = '0;
		po_ok = 1'b1;
		et = '0;
		if (st_q.byte_count < CountW'(MaxFrameBytes)) begin
			if (l3 > CountW'(L3Base) && p + CountW'(4) == l3) begin
				n.vlan = {data_byte[3:0], 8'h00};
			end
			if (l3 > CountW'(L3Base) && p + CountW'(3) == l3) begin
				n.vlan = {st_q.vlan[11:8], data_byte};
			end
			if (p + CountW'(2) == l3) begin
				n.ethertype = {data_byte, 8'h00};
			end
			if (p + CountW'(1) == l3) begin
				et = {st_q.ethertype[15:8], data_byte};
				n.ethertype = et;
				if ((et == EtVlan || et == EtQinq) && st_q.l3_start < L3LastTag) begin
					n.l3_start = st_q.l3_start + 5'd4;
				end else begin
					n.ip_kind = (et == EtIpv4) ? IpV4 : ((et == EtIpv6) ? IpV6 : IpNone);
				end
			end
			if (n.ip_kind != IpNone && p >= l3) begin
				rel = p - l3;
				if (n.ip_kind == IpV4) begin
					if (rel == 0) n.ip_hlen = {data_byte[3:0], 2'b00};
					if (rel == 6 && data_byte[4:0] != 5'd0) n.later_frag = 1'b1;
					if (rel == 7 && data_byte != 8'd0) n.later_frag = 1'b1;
					if (rel == 8) n.ttl = data_byte;
					if (rel == 9) n.proto = data_byte;
				end else begin
					if (rel == 0) n.ip_hlen = 6'd40;
					if (rel == 6) n.proto = data_byte;
					if (rel == 7) n.ttl = data_byte;
				end
				if (n.ip_hlen >= 6'd20 && rel >= CountW'(n.ip_hlen)) begin
					r4 = rel - CountW'(n.ip_hlen);
					pr = (n.ip_kind == IpV4 && n.later_frag) ? 8'd0 : n.proto;
					if (pr == ProtoTcp || pr == ProtoUdp) begin
						if (r4 == 0) n.sport = {data_byte, 8'h00};
						if (r4 == 1) n.sport = {st_q.sport[15:8], data_byte};
						if (r4 == 2) n.dport = {data_byte, 8'h00};
						if (r4 == 3) n.dport = {st_q.dport[15:8], data_byte};
					end
					if (pr == ProtoTcp) begin
						if (r4 == 12) n.tcp_hlen = {data_byte[7:4], 2'b00};
						if (r4 == 13) n.flags = data_byte;
						po = CountW'(n.tcp_hlen);
						po_ok = n.tcp_hlen >= 6'd20;
					end else if (pr == ProtoUdp) begin
						po = CountW'(8);
					end
					if (po_ok && r4 == po) n.first_payload = data_byte;
					if (po_ok && r4 == po + CountW'(5)) n.hs_type = data_byte;
				end
			end
			n.byte_count = st_q.byte_count + CountW'(1);
		end
	end

	assign nxt = n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= clr;
		end else if (take) begin
			if (end_of_frame) begin
				st_q <= clr;
			end else begin
				st_q <= n;
			end
		end
	end

endmodule

// File: rtl/fhc_classify.sv
// ----------------------------------------------------------------------------
// fhc_classify: frame classification
// Turns the final parse state of a frame into one result.
// ----------------------------------------------------------------------------
module fhc_classify (
	input  fhc_pkg::parse_t  st,
	input  logic             raw_frame_mode,
	output fhc_pkg::result_t res
);
	import fhc_pkg::*;

	logic [CountW-1:0] len;
	logic [CountW:0] l3;
	logic [CountW:0] l4;
	logic [CountW:0] payoff;
	logic [CountW:0] avail;
	logic [7:0] pr;
	logic [3:0] kind;
	logic ok;

	always_comb begin
		res = '0;
		len = st.byte_count;
		res.frame_length = len;
		l3 = (CountW+1)'(st.l3_start);
		pr = (st.ip_kind == IpV4 && st.later_frag) ? 8'd0 : st.proto;
		l4 = l3 + (CountW+1)'(st.ip_hlen);
		payoff = l4;
		if (pr == ProtoTcp) payoff = l4 + (CountW+1)'(st.tcp_hlen);
		else if (pr == ProtoUdp) payoff = l4 + (CountW+1)'(8);
		avail = ({1'b0, len} > payoff) ? {1'b0, len} - payoff : '0;
		ok = 1'b1;
		kind = KindAggregate;
		if ({1'b0, len} < l3) begin
			ok = 1'b0;
		end else if (raw_frame_mode) begin
			res.frame_kind = KindRaw;
			res.vlan_id = st.vlan;
			res.ether_type = st.ethertype;
			ok = 1'b0;
		end else if (st.ip_kind == IpNone) begin
			if (st.ethertype == EtArp) begin
				res.frame_kind = KindArp;
				res.vlan_id = st.vlan;
				res.ether_type = st.ethertype;
				res.payload_offset = CountW'(st.l3_start);
			end
			ok = 1'b0;
		end else begin
			if (st.ip_kind == IpV4) begin
				if ({1'b0, len} < l3 + (CountW+1)'(20)) ok = 1'b0;
				if (st.ip_hlen < 6'd20 || st.ip_hlen > 6'd60) ok = 1'b0;
			end else if ({1'b0, len} < l3 + (CountW+1)'(40)) begin
				ok = 1'b0;
			end
			if (pr == ProtoTcp) begin
				if ({1'b0, len} < l4 + (CountW+1)'(20)) ok = 1'b0;
				if (st.tcp_hlen < 6'd20 || st.tcp_hlen > 6'd60) ok = 1'b0;
			end else if (pr == ProtoUdp) begin
				if ({1'b0, len} < l4 + (CountW+1)'(8)) ok = 1'b0;
			end
		end
		if (pr == ProtoUdp && (st.sport == 16'd53 || st.dport == 16'd53 ||
				st.sport == 16'd5353 || st.dport == 16'd5353)) begin
			kind = KindDns;
		end else if (pr == ProtoTcp && avail >= (CountW+1)'(6) &&
				st.first_payload == 8'h16) begin
			if (st.hs_type == 8'h01) kind = KindTlsClient;
			else if (st.hs_type == 8'h02) kind = KindTlsServer;
		end else if (pr == ProtoUdp && (st.dport == 16'd1900 || st.sport == 16'd1900)) begin
			kind = KindSsdp;
		end else if (pr == ProtoUdp && (st.dport == 16'd67 || st.dport == 16'd68)) begin
			kind = KindDhcp;
		end
		if (ok) begin
			res.frame_kind = kind;
			res.vlan_id = st.vlan;
			res.ether_type = st.ethertype;
			res.ip_version = st.ip_kind;
			res.l4_protocol = pr;
			res.ip_ttl = st.ttl;
			if (pr == ProtoTcp || pr == ProtoUdp) begin
				res.src_port = st.sport;
				res.dst_port = st.dport;
			end
			if (pr == ProtoTcp) res.tcp_flag_bits = st.flags;
			res.payload_offset = payoff[CountW-1:0];
		end
	end

endmodule

// File: rtl/frame_header_classifier_unit.sv
// ----------------------------------------------------------------------------
// frame_header_classifier_unit: Ethernet/IP/L4 header classifier
// Parses a byte stream per frame and gives one classification per frame.
// ----------------------------------------------------------------------------
// One frame byte is taken in every cycle with in_valid high and in_stall low.
// The byte updates the parse state registers; on the last byte the
// classification is computed from the updated state and registered into a
// two-entry output buffer. Input stall rises only when both entries are full.
module frame_header_classifier_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        end_of_frame,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  frame_kind,
	output logic [11:0] vlan_id,
	output logic [15:0] ether_type,
	output logic [1:0]  ip_version,
	output logic [7:0]  l4_protocol,
	output logic [7:0]  ip_ttl,
	output logic [15:0] src_port,
	output logic [15:0] dst_port,
	output logic [7:0]  tcp_flag_bits,
	output logic [13:0] payload_offset,
	output logic [13:0] frame_length
);
	import fhc_pkg::*;

	logic raw_mode_q;
	logic take;
	parse_t nxt;
	result_t res;
	result_t main_q;
	result_t skid_q;
	logic main_v_q;
	logic skid_v_q;
	logic push;
	logic pop;

	assign in_stall = skid_v_q;
	assign take = in_valid && !in_stall;
	assign push = take && end_of_frame;
	assign pop = main_v_q && !out_stall;

	fhc_parser u_parser (
		.clk(clk), .arst_n(arst_n), .take(take),
		.data_byte(data_byte), .end_of_frame(end_of_frame), .nxt(nxt)
	);

	fhc_classify u_classify (.st(nxt), .raw_frame_mode(raw_mode_q), .res(res));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_mode_q <= 1'b0;
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (cfg_we) raw_mode_q <= cfg_wdata;
			if (!main_v_q || pop) begin
				main_v_q <= skid_v_q || push;
				skid_v_q <= 1'b0;
			end else if (push) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!main_v_q || pop) begin
			main_q <= skid_v_q ? skid_q : res;
		end
		if (push && main_v_q && !pop) skid_q <= res;
	end

	assign out_valid = main_v_q;
	assign frame_kind = main_q.frame_kind;
	assign vlan_id = main_q.vlan_id;
	assign ether_type = main_q.ether_type;
	assign ip_version = main_q.ip_version;
	assign l4_protocol = main_q.l4_protocol;
	assign ip_ttl = main_q.ip_ttl;
	assign src_port = main_q.src_port;
	assign dst_port = main_q.dst_port;
	assign tcp_flag_bits = main_q.tcp_flag_bits;
	assign payload_offset = main_q.payload_offset;
	assign frame_length = main_q.frame_length;

endmodule
